// ===== src/jlrv_pkg.sv =====
// Shared constants and types for the joint limit repulsion velocity block.
package jlrv_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MAG_W      = DATA_WIDTH - 1;
  // Width of the quotient gain * 2^FRAC_BITS / d.
  localparam int QW         = MAG_W + FRAC_BITS;
  // Width used for limit comparisons, wide enough that limit +/- margin never wraps.
  localparam int EXT_W      = DATA_WIDTH + 2;

  localparam logic [MAG_W-1:0] GAIN_RESET = MAG_W'(65536);
  localparam logic [MAG_W-1:0] VMAX_RESET = MAG_W'(65536);

  typedef enum logic [1:0] {
    REG_GAIN = 2'd0,
    REG_VMAX = 2'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ZONE_FREE    = 3'd0,
    ZONE_BELOW   = 3'd1,
    ZONE_NEAR_LO = 3'd2,
    ZONE_ABOVE   = 3'd3,
    ZONE_NEAR_HI = 3'd4
  } zone_t;

endpackage

// ===== src/joint_limit_repulsion_velocity.sv =====
// Top level: pipelined joint limit repulsion velocity with two restoring dividers.
//
//  channel | ports                                              | direction
//  in      | in_valid/in_ready, position, lower/upper_limit, margin | input
//  out     | out_valid/out_ready, avoid_velocity, zone          | output
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data           | input
//
// One item enters per cycle unless the output stalls.
// The depth is set by the two restoring dividers, one quotient bit per stage.
// Reset clears all valid bits and loads gain and max velocity with 1.0.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Configuration writes are always accepted.
module joint_limit_repulsion_velocity (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [jlrv_pkg::DATA_WIDTH-1:0] in_position,
  input  logic signed [jlrv_pkg::DATA_WIDTH-1:0] in_lower_limit,
  input  logic signed [jlrv_pkg::DATA_WIDTH-1:0] in_upper_limit,
  input  logic        [jlrv_pkg::MAG_W-1:0]      in_margin,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [jlrv_pkg::DATA_WIDTH-1:0] out_avoid_velocity,
  output logic        [2:0]                      out_zone,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic        [1:0]                      cfg_index,
  input  logic        [jlrv_pkg::DATA_WIDTH-1:0] cfg_data
);

  localparam int MAG_W = jlrv_pkg::MAG_W;
  localparam int QW    = jlrv_pkg::QW;
  localparam int EXT_W = jlrv_pkg::EXT_W;
  localparam int DW    = jlrv_pkg::DATA_WIDTH;

  logic [MAG_W-1:0] gain_r;
  logic [MAG_W-1:0] vmax_r;
  logic             adv;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= jlrv_pkg::GAIN_RESET;
      vmax_r <= jlrv_pkg::VMAX_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == jlrv_pkg::REG_GAIN) begin
        gain_r <= cfg_data[MAG_W-1:0];
      end else if (cfg_index == jlrv_pkg::REG_VMAX) begin
        vmax_r <= cfg_data[MAG_W-1:0];
      end
    end
  end

  // Stage registers: index 0 is the classify stage, index j holds j quotient bits.
  logic                  v_r  [QW+1];
  jlrv_pkg::zone_t       z_r  [QW+1];
  logic                  zf_r [QW+1];
  logic [MAG_W-1:0]      d_r  [QW+1];
  logic [MAG_W-1:0]      m_r  [QW+1];
  logic [MAG_W-1:0]      ra_r [QW+1];
  logic [MAG_W-1:0]      rb_r [QW+1];
  logic [QW-1:0]         qa_r [QW+1];
  logic [QW-1:0]         qb_r [QW+1];

  logic                  f_v_r;
  jlrv_pkg::zone_t       f_z_r;
  logic                  f_zf_r;
  logic [QW-1:0]         f_diff_r;

  logic                  o_v_r;
  logic signed [DW-1:0]  o_vel_r;
  jlrv_pkg::zone_t       o_z_r;

  // The whole pipeline moves unless the output holds an item that is not taken.
  assign adv      = !o_v_r || out_ready;
  assign in_ready = adv;

  // Classify stage: zone decision and distance to the active limit.
  logic signed [EXT_W-1:0] pos_x, lo_x, hi_x, mrg_x, dist_x;
  jlrv_pkg::zone_t         zone_nxt;
  always_comb begin
    pos_x  = EXT_W'(in_position);
    lo_x   = EXT_W'(in_lower_limit);
    hi_x   = EXT_W'(in_upper_limit);
    mrg_x  = EXT_W'({1'b0, in_margin});
    zone_nxt = jlrv_pkg::ZONE_FREE;
    if (pos_x < lo_x) begin
      zone_nxt = jlrv_pkg::ZONE_BELOW;
    end else if (pos_x < lo_x + mrg_x) begin
      zone_nxt = jlrv_pkg::ZONE_NEAR_LO;
    end
    if (pos_x > hi_x) begin
      zone_nxt = jlrv_pkg::ZONE_ABOVE;
    end else if (pos_x > hi_x - mrg_x) begin
      zone_nxt = jlrv_pkg::ZONE_NEAR_HI;
    end
    if (zone_nxt == jlrv_pkg::ZONE_NEAR_HI) begin
      dist_x = hi_x - pos_x;
    end else begin
      dist_x = pos_x - lo_x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      z_r[0]  <= zone_nxt;
      d_r[0]  <= dist_x[MAG_W-1:0];
      zf_r[0] <= (dist_x[MAG_W-1:0] == '0);
      m_r[0]  <= in_margin;
      ra_r[0] <= '0;
      rb_r[0] <= '0;
      qa_r[0] <= '0;
      qb_r[0] <= '0;
    end
  end

  // Numerator gain * 2^FRAC_BITS, fed to the dividers one bit per stage.
  logic [QW-1:0] num_w;
  assign num_w = {gain_r, {jlrv_pkg::FRAC_BITS{1'b0}}};

  // Divider stages: one restoring step for each of the two quotients.
  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [MAG_W:0]   sa, sb;
    logic             ga, gb;
    logic [MAG_W:0]   na, nb;
    always_comb begin
      sa = {ra_r[j-1], num_w[QW-j]};
      sb = {rb_r[j-1], num_w[QW-j]};
      ga = (sa >= {1'b0, d_r[j-1]});
      gb = (sb >= {1'b0, m_r[j-1]});
      na = ga ? (sa - {1'b0, d_r[j-1]}) : sa;
      nb = gb ? (sb - {1'b0, m_r[j-1]}) : sb;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (adv) begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        z_r[j]  <= z_r[j-1];
        zf_r[j] <= zf_r[j-1];
        d_r[j]  <= d_r[j-1];
        m_r[j]  <= m_r[j-1];
        ra_r[j] <= na[MAG_W-1:0];
        rb_r[j] <= nb[MAG_W-1:0];
        qa_r[j] <= {qa_r[j-1][QW-2:0], ga};
        qb_r[j] <= {qb_r[j-1][QW-2:0], gb};
      end
    end
  end

  // Difference stage: gain/dist - gain/margin, never negative in a near zone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_z_r    <= z_r[QW];
      f_zf_r   <= zf_r[QW];
      f_diff_r <= qa_r[QW] - qb_r[QW];
    end
  end

  // Output stage: saturate to max velocity, apply the zone direction, zero if free.
  logic [MAG_W-1:0]     mag;
  logic signed [DW-1:0] vel_nxt;
  always_comb begin
    if (f_zf_r || (f_diff_r > QW'(vmax_r))) begin
      mag = vmax_r;
    end else begin
      mag = f_diff_r[MAG_W-1:0];
    end
    case (f_z_r)
      jlrv_pkg::ZONE_BELOW:   vel_nxt = DW'(vmax_r);
      jlrv_pkg::ZONE_NEAR_LO: vel_nxt = DW'(mag);
      jlrv_pkg::ZONE_ABOVE:   vel_nxt = -DW'(vmax_r);
      jlrv_pkg::ZONE_NEAR_HI: vel_nxt = -DW'(mag);
      default:                vel_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (adv) begin
      o_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_vel_r <= vel_nxt;
      o_z_r   <= f_z_r;
    end
  end

  assign out_valid          = o_v_r;
  assign out_avoid_velocity = o_vel_r;
  assign out_zone           = o_z_r;

  // A free joint gets no command.
  a_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && o_z_r == jlrv_pkg::ZONE_FREE) |-> (o_vel_r == '0))
    else $error("free zone with nonzero velocity");

  // Near the lower limit the command stays within zero and max velocity.
  a_near_lo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && o_z_r == jlrv_pkg::ZONE_NEAR_LO) |->
      (!o_vel_r[DW-1] && o_vel_r <= DW'(vmax_r)))
    else $error("lower margin command out of range");

  // An item taken in a cycle with the pipeline advancing lands in stage zero.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted item lost at pipeline entry");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (o_v_r && !out_ready) |=> (o_v_r && $stable(o_vel_r) && $stable(o_z_r)))
    else $error("stalled result changed");

endmodule
